// ----- rtl/ttl_pkg.sv -----
// ttl_pkg: shared types, widths and codes of the tick timer list
// used by the channel interfaces, the controller and the datapath
// no dependencies

package ttl_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int TAG_W         = 8;
   localparam int WAIT_W        = 16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_EXPIRED  = 1'b0;
   localparam logic KIND_REJECTED = 1'b1;

   typedef struct packed {
      logic push_write;
      logic push_reject;
      logic walk_start;
      logic advance;
      logic issue;
      logic flush_pend;
      logic walk_end;
   } ttl_cmd_type;

   typedef struct packed {
      logic full;
      logic rd_more;
      logic s2_valid;
      logic s2_expire;
      logic pend_valid;
      logic out_free;
   } ttl_stat_type;

endpackage

// ----- rtl/ttl_chan_if.sv -----
// ttl_req_if and ttl_rsp_if: valid/ready channels of the tick timer list
// depends on ttl_pkg for the payload widths

interface ttl_req_if;
   import ttl_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [TAG_W-1:0]  tag;
   logic [WAIT_W-1:0] wait_ticks;

   modport source (output valid, output opcode, output tag, output wait_ticks, input ready);
   modport sink   (input valid, input opcode, input tag, input wait_ticks, output ready);
endinterface

interface ttl_rsp_if;
   import ttl_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [TAG_W-1:0] tag_res;
   logic             last;

   modport source (output valid, output kind, output tag_res, output last, input ready);
   modport sink   (input valid, input kind, input tag_res, input last, output ready);
endinterface

// ----- rtl/ttl_ctrl.sv -----
// ttl_ctrl: state machine that sequences pushes and the tick walk
// depends on ttl_pkg for the command and status structs

module ttl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  req_opcode,
   output logic                  req_ready,
   input  ttl_pkg::ttl_stat_type stat,
   output ttl_pkg::ttl_cmd_type  cmd
);
   import ttl_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_fire) begin
               if (req_opcode == OP_TICK) begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_WALK;
               end else if (stat.full) begin
                  cmd.push_reject = 1'b1;
               end else begin
                  cmd.push_write = 1'b1;
               end
            end
         end
         ST_WALK: begin
            // hold the walk while an expiry has nowhere to go
            cmd.advance = !(stat.s2_valid && stat.s2_expire && stat.pend_valid
                            && !stat.out_free);
            cmd.issue   = cmd.advance && stat.rd_more;
            if (!stat.rd_more && !stat.s2_valid) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               cmd.walk_end = 1'b1;
               state_in     = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush_pend = 1'b1;
               cmd.walk_end   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ttl_dpath.sv -----
// ttl_dpath: entry memories, walk pointers, pending expiry and result register
// depends on ttl_pkg for widths, codes and the command and status structs

module ttl_dpath #(
   parameter int SLOTS = ttl_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ttl_pkg::ttl_cmd_type       cmd,
   output ttl_pkg::ttl_stat_type      stat,
   input  logic [ttl_pkg::TAG_W-1:0]  req_tag,
   input  logic [ttl_pkg::WAIT_W-1:0] req_wait_ticks,
   output logic                       out_valid,
   output logic                       out_kind,
   output logic [ttl_pkg::TAG_W-1:0]  out_tag,
   output logic                       out_last,
   input  logic                       out_ready
);
   import ttl_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [TAG_W-1:0]  mem_tag [SLOTS];
   logic [WAIT_W-1:0] mem_rem [SLOTS];

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [WAIT_W-1:0] rd_rem_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic              out_last_ff, out_last_in;

   logic              s2_expire;
   logic              keep;
   logic              drop;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TAG_W-1:0]  wr_tag;
   logic [WAIT_W-1:0] wr_rem;

   assign s2_expire = (rd_rem_ff == '0);
   assign keep      = cmd.advance && s2_valid_ff && !s2_expire;
   assign drop      = cmd.advance && s2_valid_ff && s2_expire;

   assign stat.full       = (count_ff >= CW'(SLOTS));
   assign stat.rd_more    = (rd_ptr_ff < count_ff);
   assign stat.s2_valid   = s2_valid_ff;
   assign stat.s2_expire  = s2_expire;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = !out_valid_ff || out_ready;

   // survivors are compacted toward the head, behind the read pointer
   always_comb begin
      wr_en   = cmd.push_write || keep;
      wr_addr = cmd.push_write ? count_ff[AW-1:0] : wr_ptr_ff[AW-1:0];
      wr_tag  = cmd.push_write ? req_tag : rd_tag_ff;
      wr_rem  = cmd.push_write ? req_wait_ticks : rd_rem_ff - WAIT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_tag[wr_addr] <= wr_tag;
         mem_rem[wr_addr] <= wr_rem;
      end
      if (cmd.issue) begin
         rd_tag_ff <= mem_tag[rd_ptr_ff[AW-1:0]];
         rd_rem_ff <= mem_rem[rd_ptr_ff[AW-1:0]];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      s2_valid_in   = s2_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_kind_in   = out_kind_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;

      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.walk_end) begin
         count_in = wr_ptr_ff;
      end

      if (cmd.walk_start) begin
         rd_ptr_in     = '0;
         wr_ptr_in     = '0;
         s2_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
      end
      if (cmd.issue) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
      end
      if (cmd.advance) begin
         s2_valid_in = cmd.issue;
      end
      if (keep) begin
         wr_ptr_in = wr_ptr_ff + CW'(1);
      end

      // an expiry waits in pend until the next one shows it was not the last
      if (drop) begin
         pend_valid_in = 1'b1;
         pend_tag_in   = rd_tag_ff;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = KIND_EXPIRED;
            out_tag_in   = pend_tag_ff;
            out_last_in  = 1'b0;
         end
      end
      if (cmd.flush_pend) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_EXPIRED;
         out_tag_in    = pend_tag_ff;
         out_last_in   = 1'b1;
      end
      if (cmd.push_reject) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_REJECTED;
         out_tag_in   = req_tag;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         s2_valid_ff   <= s2_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_tag_ff <= pend_tag_in;
      out_kind_ff <= out_kind_in;
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_tag   = out_tag_ff;
   assign out_last  = out_last_ff;

endmodule

// ----- rtl/tick_timer_list_core.sv -----
// tick_timer_list_core: top level of the tick timer list
// depends on ttl_pkg, ttl_req_if, ttl_rsp_if, ttl_ctrl and ttl_dpath
//
// requests arrive on req_ch: opcode 0 pushes (tag, wait_ticks) onto the tail
// of the list, opcode 1 is one timer tick. results leave on rsp_ch with kind
// (0 expired, 1 push rejected), tag_res and last on the final result of a
// request. a push into a full list gives one reject result in the next
// cycle. a tick walks the live entries one per cycle, while rsp_ch does
// not hold the walk, through the single read port of the entry memory,
// and the next request is taken at the earliest when the last expiry is
// also shown. expiries come out in list order while the survivors are
// compacted in place. a request is taken only while the block is idle and
// its result register is free or being emptied. when rsp_ch stalls, one
// expiry waits in the result register and one in a holding register, the
// walk halts on the next expiry and resumes once the result register
// drains; nothing is dropped. reset empties the list and drops any result
// not yet taken; the entry memory itself is not cleared.

module tick_timer_list_core #(
   parameter int SLOTS = ttl_pkg::SLOTS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ttl_req_if.sink   req_ch,
   ttl_rsp_if.source rsp_ch
);
   import ttl_pkg::*;

   ttl_cmd_type  cmd;
   ttl_stat_type stat;
   logic         req_ready;
   logic         req_fire;

   assign req_fire     = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   ttl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ttl_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_tag        (req_ch.tag),
      .req_wait_ticks (req_ch.wait_ticks),
      .out_valid      (rsp_ch.valid),
      .out_kind       (rsp_ch.kind),
      .out_tag        (rsp_ch.tag_res),
      .out_last       (rsp_ch.last),
      .out_ready      (rsp_ch.ready)
   );

endmodule
